@@ hw/rtl/ssc_pkg.sv @@
// ---------------------------------------------------------------------------
// ssc_pkg
// shared constants and arctangent table for the stanley steering controller
// ---------------------------------------------------------------------------
package ssc_pkg;

  localparam int TAB_LEN   = 24;
  localparam int PRESCALE  = 8;
  localparam int CW        = 52;   // cordic datapath width
  localparam int AW        = 34;   // angle width, q.30 with headroom
  localparam logic [17:0] INVK_Q18 = 18'd159189;
  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;

  localparam logic [1:0] REG_SPEED     = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_LIMIT     = 2'd3;

  function automatic logic signed [AW-1:0] atan_tab(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
        3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
        6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
        9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
        12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
        15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
        18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
        21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
        default: t = 32'h0;
      endcase
      atan_tab = AW'(signed'({1'b0, t}));
    end
  endfunction

endpackage

@@ hw/rtl/ssc_if.sv @@
// ---------------------------------------------------------------------------
// ssc_if
// valid/ready channels of the steering controller
// ---------------------------------------------------------------------------
interface ssc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] yaw;
  modport source (output valid, next_x, next_y, prev_x, prev_y, pos_x, pos_y, yaw,
                  input ready);
  modport sink (input valid, next_x, next_y, prev_x, prev_y, pos_x, pos_y, yaw,
                output ready);
endinterface

interface ssc_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] speed_out;
  logic signed [15:0] steering;
  logic               on_track;
  logic               degenerate_segment;
  modport source (output valid, speed_out, steering, on_track, degenerate_segment,
                  input ready);
  modport sink (input valid, speed_out, steering, on_track, degenerate_segment,
                output ready);
endinterface

interface ssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/stanley_steering_controller_core.sv @@
// ---------------------------------------------------------------------------
// stanley_steering_controller_core
// stanley path-tracking steering: cross-track error, heading error, command
// ---------------------------------------------------------------------------
// Fully pipelined: one pose word is accepted every cycle unless the output
// stalls. The datapath is two chained vectoring CORDICs of CORDIC_STAGES
// stages each (track angle with the rotated offset, then the error
// correction angle), plus the input fold, the inverse-gain multiply, the
// gain multiply, the second fold and the output register holding the
// round/clamp.
// The pipeline advances whenever its last stage is empty or being taken, so
// stalls at the output hold every stage without loss.
module stanley_steering_controller_core #(
  parameter int POS_FRAC_BITS   = 16,
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STAGES   = 16
) (
  input logic clk,
  input logic rst,
  ssc_in_if.sink    in_ch,
  ssc_out_if.source out_ch,
  ssc_cfg_if.sink   cfg
);
  localparam int CW = ssc_pkg::CW;
  localparam int AW = ssc_pkg::AW;
  localparam int NS = CORDIC_STAGES;
  localparam int ASH = 30 - ANGLE_FRAC_BITS;

  typedef struct packed {
    logic                 degen;
    logic signed [AW-1:0] ang;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    logic signed [15:0]   yaw;
  } c1_t;

  typedef struct packed {
    logic                 degen;
    logic signed [AW-1:0] psi;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 on;
    logic                 zero;
  } c2_t;

  // configuration
  logic [15:0] speed, gain;
  logic [30:0] track_thresh;
  logic [14:0] steer_limit;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= 16'd512;
      gain <= 16'd256;
      track_thresh <= 31'd6554;
      steer_limit <= 15'd4289;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ssc_pkg::REG_SPEED:     speed <= cfg.data[15:0];
        ssc_pkg::REG_GAIN:      gain <= cfg.data[15:0];
        ssc_pkg::REG_THRESHOLD: track_thresh <= cfg.data[30:0];
        ssc_pkg::REG_LIMIT:     steer_limit <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 0: differences and quadrant fold ----------------
  logic  v0;
  c1_t   s0;
  c1_t   s0_next;
  always_comb begin
    logic signed [CW-1:0] dx, dy, pu, pv;
    dx = (CW'(in_ch.next_x) - CW'(in_ch.prev_x)) <<< ssc_pkg::PRESCALE;
    dy = (CW'(in_ch.next_y) - CW'(in_ch.prev_y)) <<< ssc_pkg::PRESCALE;
    pu = (CW'(in_ch.prev_x) - CW'(in_ch.pos_x)) <<< ssc_pkg::PRESCALE;
    pv = (CW'(in_ch.prev_y) - CW'(in_ch.pos_y)) <<< ssc_pkg::PRESCALE;
    s0_next.degen = (dx == '0) && (dy == '0);
    s0_next.yaw = in_ch.yaw;
    if (dx < 0) begin
      s0_next.ang = (dy >= 0) ? ssc_pkg::PI_Q30 : -ssc_pkg::PI_Q30;
      s0_next.x = -dx; s0_next.y = -dy; s0_next.u = -pu; s0_next.v = -pv;
    end else begin
      s0_next.ang = '0;
      s0_next.x = dx; s0_next.y = dy; s0_next.u = pu; s0_next.v = pv;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_ch.valid;
  end
  always_ff @(posedge clk) if (adv) s0 <= s0_next;

  // ---------------- cordic 1 ----------------
  logic  c1v [NS+1];
  c1_t   c1s [NS+1];
  assign c1v[0] = v0;
  assign c1s[0] = s0;
  for (genvar i = 0; i < NS; i++) begin : g_c1
    c1_t nx;
    always_comb begin
      nx = c1s[i];
      if (i < ssc_pkg::TAB_LEN) begin
        if (c1s[i].y > 0) begin
          nx.x = c1s[i].x + (c1s[i].y >>> i);
          nx.y = c1s[i].y - (c1s[i].x >>> i);
          nx.u = c1s[i].u + (c1s[i].v >>> i);
          nx.v = c1s[i].v - (c1s[i].u >>> i);
          nx.ang = c1s[i].ang + ssc_pkg::atan_tab(i);
        end else begin
          nx.x = c1s[i].x - (c1s[i].y >>> i);
          nx.y = c1s[i].y + (c1s[i].x >>> i);
          nx.u = c1s[i].u - (c1s[i].v >>> i);
          nx.v = c1s[i].v + (c1s[i].u >>> i);
          nx.ang = c1s[i].ang - ssc_pkg::atan_tab(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) c1v[i+1] <= 1'b0;
      else if (adv) c1v[i+1] <= c1v[i];
    end
    always_ff @(posedge clk) if (adv) c1s[i+1] <= nx;
  end

  // degenerate: zero vector still rotates u,v and the angle at every stage; flagged anyway
  // ---------------- stage a: inverse gain multiply, psi ----------------
  logic                  va;
  logic                  a_degen;
  logic signed [CW+18:0] a_prod;
  logic signed [AW-1:0]  a_psi;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= c1v[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [AW-1:0] p;
      p = c1s[NS].ang - (AW'(c1s[NS].yaw) <<< ASH);
      if (p > ssc_pkg::PI_Q30) p = p - (ssc_pkg::PI_Q30 <<< 1);
      else if (p < -ssc_pkg::PI_Q30) p = p + (ssc_pkg::PI_Q30 <<< 1);
      a_psi <= p;
      a_degen <= c1s[NS].degen;
      a_prod <= c1s[NS].v * $signed({1'b0, ssc_pkg::INVK_Q18});
    end
  end

  // ---------------- stage b: error, on-track, gain multiply ----------------
  logic                 vb;
  logic                 b_degen, b_on;
  logic signed [AW-1:0] b_psi;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_x;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [CW+18:0] e;
      logic signed [CW+18:0] ae;
      e = a_prod >>> (18 + ssc_pkg::PRESCALE);
      ae = (e < 0) ? -e : e;
      b_on <= ae <= (CW+19)'({1'b0, track_thresh});
      b_degen <= a_degen;
      b_psi <= a_psi;
      // error fits well within 40 bits; gain*e within CW
      b_y <= CW'($signed(e[39:0])) * CW'($signed({1'b0, gain}));
      b_x <= CW'({1'b0, speed}) <<< POS_FRAC_BITS;
    end
  end

  // ---------------- stage c: fold for cordic 2 ----------------
  logic  vc;
  c2_t   cs;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (adv) vc <= vb;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cs.degen <= b_degen;
      cs.on <= b_on;
      cs.psi <= b_psi;
      cs.zero <= (b_x == '0) && (b_y == '0);
      if (b_x < 0) begin
        cs.ang <= (b_y >= 0) ? ssc_pkg::PI_Q30 : -ssc_pkg::PI_Q30;
        cs.x <= -b_x; cs.y <= -b_y;
      end else begin
        cs.ang <= '0; cs.x <= b_x; cs.y <= b_y;
      end
    end
  end

  // ---------------- cordic 2 ----------------
  logic  c2v [NS+1];
  c2_t   c2s [NS+1];
  assign c2v[0] = vc;
  assign c2s[0] = cs;
  for (genvar i = 0; i < NS; i++) begin : g_c2
    c2_t nx;
    always_comb begin
      nx = c2s[i];
      if (i < ssc_pkg::TAB_LEN) begin
        if (c2s[i].y > 0) begin
          nx.x = c2s[i].x + (c2s[i].y >>> i);
          nx.y = c2s[i].y - (c2s[i].x >>> i);
          nx.ang = c2s[i].ang + ssc_pkg::atan_tab(i);
        end else begin
          nx.x = c2s[i].x - (c2s[i].y >>> i);
          nx.y = c2s[i].y + (c2s[i].x >>> i);
          nx.ang = c2s[i].ang - ssc_pkg::atan_tab(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) c2v[i+1] <= 1'b0;
      else if (adv) c2v[i+1] <= c2v[i];
    end
    always_ff @(posedge clk) if (adv) c2s[i+1] <= nx;
  end

  // ---------------- stage d: sum, round, clamp ----------------
  logic signed [15:0] d_steer;
  always_comb begin
    logic signed [AW:0] sum, st, lim, corr;
    // zero vector (speed and error term both zero) gives angle 0
    corr = c2s[NS].zero ? '0 : (AW+1)'(c2s[NS].ang);
    sum = (AW+1)'(c2s[NS].psi) + corr;
    st = (sum + ((AW+1)'(1) <<< (ASH - 1))) >>> ASH;
    lim = (AW+1)'({1'b0, steer_limit});
    if (st > lim) st = lim;
    if (st < -lim) st = -lim;
    if (c2s[NS].degen || c2s[NS].on) d_steer = '0;
    else d_steer = st[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= c2v[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.speed_out <= speed;
      out_ch.steering <= d_steer;
      out_ch.on_track <= c2s[NS].on && !c2s[NS].degen;
      out_ch.degenerate_segment <= c2s[NS].degen;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// checks the stanley steering controller against a local cordic predictor:
// directed corner poses, then random path segments under several settings
// ---------------------------------------------------------------------------
module tb_top;

  localparam int POS_FRAC = 16;
  localparam int ANG_FRAC = 13;
  localparam int STAGES   = 16;
  localparam int LATENCY  = 2 * STAGES + 4;
  localparam longint PI_VAL = 64'sd3373259426;

  typedef struct packed {
    logic [15:0] speed_out;
    logic [15:0] steering;
    logic        on_track;
    logic        degenerate_segment;
  } steer_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  ssc_in_if  in_ch();
  ssc_out_if out_ch();
  ssc_cfg_if cfg();

  stanley_steering_controller_core #(
    .POS_FRAC_BITS(POS_FRAC), .ANGLE_FRAC_BITS(ANG_FRAC), .CORDIC_STAGES(STAGES)
  ) u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

  // local copy of the configuration
  logic [15:0] cur_speed;
  logic [15:0] cur_gain;
  logic [30:0] cur_thresh;
  logic [14:0] cur_limit;

  steer_word_t expected_q[$];
  int  n_errors = 0;
  int  n_results = 0;
  int  n_on = 0;
  int  n_degen = 0;
  bit  idle_on = 1'b1;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    return longint'(ssc_pkg::atan_tab(i));
  endfunction

  // vectoring cordic, rotating (u,v) alongside
  function automatic longint cordic_angle(longint x, longint y, ref longint u,
                                          ref longint v);
    longint ang;
    longint nx, ny, nu, nv;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? PI_VAL : -PI_VAL;
      x = -x; y = -y; u = -u; v = -v;
    end
    for (int i = 0; i < STAGES && i < ssc_pkg::TAB_LEN; i++) begin
      if (y > 0) begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i);
        nu = u + floor_shr(v, i); nv = v - floor_shr(u, i);
        ang += atan_entry(i);
      end else begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i);
        nu = u - floor_shr(v, i); nv = v + floor_shr(u, i);
        ang -= atan_entry(i);
      end
      x = nx; y = ny; u = nu; v = nv;
    end
    return ang;
  endfunction

  function automatic steer_word_t steering_command(logic signed [31:0] nx,
      logic signed [31:0] ny, logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] vx, logic signed [31:0] vy, logic signed [15:0] yaw);
    steer_word_t r;
    longint dx, dy, u, v, du, dv, theta, err, aerr, psi, corr, steer, lim;
    dx = longint'(nx) - longint'(px);
    dy = longint'(ny) - longint'(py);
    steer = 0;
    r.on_track = 1'b0;
    r.degenerate_segment = 1'b0;
    r.speed_out = cur_speed;
    if (dx == 0 && dy == 0) begin
      r.degenerate_segment = 1'b1;
    end else begin
      u = (longint'(px) - longint'(vx)) * 256;
      v = (longint'(py) - longint'(vy)) * 256;
      theta = cordic_angle(dx * 256, dy * 256, u, v);
      err = floor_shr(v * 159189, 18 + ssc_pkg::PRESCALE);
      aerr = err < 0 ? -err : err;
      psi = theta - longint'(yaw) * (64'sd1 << (30 - ANG_FRAC));
      while (psi > PI_VAL) psi -= 2 * PI_VAL;
      while (psi < -PI_VAL) psi += 2 * PI_VAL;
      du = 0; dv = 0;
      corr = cordic_angle(longint'(cur_speed) * (64'sd1 << POS_FRAC),
                          longint'(cur_gain) * err, du, dv);
      steer = floor_shr(psi + corr + (64'sd1 << (29 - ANG_FRAC)), 30 - ANG_FRAC);
      lim = longint'(cur_limit);
      if (steer > lim) steer = lim;
      if (steer < -lim) steer = -lim;
      if (aerr <= longint'(cur_thresh)) begin
        r.on_track = 1'b1;
        steer = 0;
      end
    end
    r.steering = steer[15:0];
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 9)) @(negedge clk);
  endtask

  task automatic send_pose(logic [31:0] nx, logic [31:0] ny, logic [31:0] px,
      logic [31:0] py, logic [31:0] vx, logic [31:0] vy, logic [15:0] yaw);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      idle_burst();
    end
    in_ch.next_x <= nx; in_ch.next_y <= ny;
    in_ch.prev_x <= px; in_ch.prev_y <= py;
    in_ch.pos_x <= vx; in_ch.pos_y <= vy;
    in_ch.yaw <= yaw;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(steering_command(nx, ny, px, py, vx, vy, yaw));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      ssc_pkg::REG_SPEED:     cur_speed  = val[15:0];
      ssc_pkg::REG_GAIN:      cur_gain   = val[15:0];
      ssc_pkg::REG_THRESHOLD: cur_thresh = val[30:0];
      ssc_pkg::REG_LIMIT:     cur_limit  = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] sp, logic [15:0] gn, logic [30:0] th,
                         logic [14:0] lm);
    write_reg(ssc_pkg::REG_SPEED, {16'd0, sp});
    write_reg(ssc_pkg::REG_GAIN, {16'd0, gn});
    write_reg(ssc_pkg::REG_THRESHOLD, {1'b0, th});
    write_reg(ssc_pkg::REG_LIMIT, {17'd0, lm});
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  function automatic logic [15:0] rand_yaw();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // result checker
  always @(posedge clk) begin
    steer_word_t got, exp_w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.speed_out, out_ch.steering, out_ch.on_track,
             out_ch.degenerate_segment};
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        exp_w = expected_q.pop_front();
        n_on += exp_w.on_track;
        n_degen += exp_w.degenerate_segment;
        if (got.speed_out !== exp_w.speed_out) begin
          n_errors++;
          $display("%0t: speed_out exp %h got %h", $time, exp_w.speed_out,
                   got.speed_out);
        end
        if (got.steering !== exp_w.steering) begin
          n_errors++;
          $display("%0t: steering exp %h got %h", $time, exp_w.steering,
                   got.steering);
        end
        if (got.on_track !== exp_w.on_track) begin
          n_errors++;
          $display("%0t: on_track exp %b got %b", $time, exp_w.on_track,
                   got.on_track);
        end
        if (got.degenerate_segment !== exp_w.degenerate_segment) begin
          n_errors++;
          $display("%0t: degenerate exp %b got %b", $time,
                   exp_w.degenerate_segment, got.degenerate_segment);
        end
      end
    end
  end

  // sink stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        idle_burst();
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFFFFFF;
    mn = 32'h80000000;
    // coincident waypoints
    send_pose(32'd65536, 32'd65536, 32'd65536, 32'd65536, 0, 0, 0);
    send_pose(mn, mx, mn, mx, mx, mn, 16'h7FFF);
    // on and off the line
    send_pose(32'd655360, 0, 0, 0, 32'd100, 32'd100, 0);
    send_pose(32'd655360, 0, 0, 0, 0, 32'd65536, 0);
    send_pose(32'd655360, 0, 0, 0, 0, -32'd65536, 16'd4000);
    // backwards and vertical segments
    send_pose(-32'd655360, 0, 0, 0, 0, 32'd65536, 16'd25736);
    send_pose(-32'd655360, 0, 0, 0, 0, -32'd65536, -16'd25736);
    send_pose(0, 32'd655360, 0, 0, 32'd65536, 0, 0);
    send_pose(0, -32'd655360, 0, 0, -32'd65536, 0, 0);
    // extremes of coordinates and yaw
    send_pose(mx, mx, mn, mn, mn, mx, 16'h8000);
    send_pose(mn, mn, mx, mx, mx, mn, 16'h7FFF);
    send_pose(mx, mn, mn, mx, 0, 0, 16'hFFFF);
    send_pose(32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0001);
    drain();
    // speed zero, gain max, zero threshold, limit above pi
    set_all(16'd0, 16'hFFFF, 31'd0, 15'h7FFF);
    send_pose(32'd655360, 0, 0, 0, 0, 32'd65536, 0);
    send_pose(32'd655360, 0, 0, 0, 0, -32'd65536, 16'd25736);
    send_pose(32'd655360, 0, 0, 0, 0, 0, 16'h8000);
    send_pose(mx, mn, mn, mx, mx, mx, 16'h7FFF);
    drain();
    // speed and gain zero: correction vector is zero while off track
    set_all(16'd0, 16'd0, 31'd0, 15'h7FFF);
    send_pose(32'd655360, 0, 0, 0, 0, 32'd65536, 16'd3000);
    send_pose(-32'd655360, 0, 0, 0, 0, -32'd65536, -16'd3000);
    drain();
    // gain zero, max speed, max threshold, zero limit
    set_all(16'hFFFF, 16'd0, 31'h7FFFFFFF, 15'd0);
    send_pose(32'd655360, 0, 0, 0, 0, 32'd65536, 0);
    send_pose(mx, mn, mn, mx, 0, 0, 16'h7FFF);
    drain();
    // index values past the last register are unreachable on a two-bit index
  endtask

  task automatic random_phase(int count, logic [15:0] sp, logic [15:0] gn,
                              logic [30:0] th, logic [14:0] lm);
    logic [31:0] px, py, nx, ny, vx, vy, ox, oy;
    set_all(sp, gn, th, lm);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: send_pose(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), 16'($urandom()));
        1: begin
          px = rand_coord(); py = rand_coord();
          send_pose(px, py, px, py, rand_coord(), rand_coord(), rand_yaw());
        end
        default: begin
          // vehicle near a realistic path segment
          px = 32'($signed($urandom_range(0, 4000000)) - 2000000);
          py = 32'($signed($urandom_range(0, 4000000)) - 2000000);
          nx = px + 32'($signed($urandom_range(0, 2000000)) - 1000000);
          ny = py + 32'($signed($urandom_range(0, 2000000)) - 1000000);
          ox = 32'($signed($urandom_range(0, 40000)) - 20000);
          oy = 32'($signed($urandom_range(0, 40000)) - 20000);
          vx = px + 32'($signed(nx - px) >>> $urandom_range(1, 3)) + ox;
          vy = py + 32'($signed(ny - py) >>> $urandom_range(1, 3)) + oy;
          send_pose(nx, ny, px, py, vx, vy, rand_yaw());
        end
      endcase
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.next_x = '0; in_ch.next_y = '0; in_ch.prev_x = '0; in_ch.prev_y = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.yaw = '0;
    cfg.valid = 1'b0; cfg.index = ssc_pkg::REG_SPEED; cfg.data = '0;
    cur_speed = 16'd512; cur_gain = 16'd256; cur_thresh = 31'd6554;
    cur_limit = 15'd4289;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    test_directed();
    random_phase(100, 16'd512, 16'd256, 31'd6554, 15'd4289);
    random_phase(100, 16'($urandom()), 16'($urandom()), 31'($urandom_range(0, 20000)),
                 15'($urandom_range(0, 25736)));
    random_phase(80, 16'd1, 16'hFFFF, 31'd0, 15'd25736);
    random_phase(80, 16'd2560, 16'd128, 31'd65536, 15'd2000);
    idle_on = 1'b0;
    random_phase(90, 16'd1024, 16'd512, 31'd3000, 15'd6000);
    $display("covered %0d results, %0d on track, %0d degenerate, under corner",
             n_results, n_on, n_degen);
    $display("and random register settings, with and without stalls");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
